// ----- hw/rtl/lcd4_pkg.sv -----
// shared types, codes and constants of the character lcd 4-bit sequencer
// no dependencies
package lcd4_pkg;

    // request codes on i_op
    localparam logic [2:0] OP_INIT   = 3'd0;
    localparam logic [2:0] OP_CMD    = 3'd1;
    localparam logic [2:0] OP_DATA   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_CURSOR = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_ENABLE_HIGH   = 3'd0;
    localparam logic [2:0] CFG_ENABLE_SETTLE = 3'd1;
    localparam logic [2:0] CFG_COMMAND_WAIT  = 3'd2;
    localparam logic [2:0] CFG_DATA_WAIT     = 3'd3;
    localparam logic [2:0] CFG_CLEAR_EXTRA   = 3'd4;
    localparam logic [2:0] CFG_POWER_UP      = 3'd5;

    // configuration reset values in microseconds
    localparam logic [15:0] RST_ENABLE_HIGH   = 16'd1;
    localparam logic [15:0] RST_ENABLE_SETTLE = 16'd100;
    localparam logic [15:0] RST_COMMAND_WAIT  = 16'd2000;
    localparam logic [15:0] RST_DATA_WAIT     = 16'd50;
    localparam logic [15:0] RST_CLEAR_EXTRA   = 16'd2000;
    localparam logic [15:0] RST_POWER_UP      = 16'd50000;

    // fixed hold times in microseconds
    localparam logic [15:0] SETUP_US             = 16'd1;
    localparam logic [15:0] FIRST_NIBBLE_HOLD_US = 16'd5000;
    localparam logic [15:0] NIBBLE_HOLD_US       = 16'd200;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [3:0] CLEAR_NIBBLE = 4'h1;

    localparam int LCD4_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_INIT,
        KIND_BYTE,
        KIND_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       rs;
        logic [7:0] byte_val;
    } t_req;

    typedef struct packed {
        logic [15:0] enable_high_us;
        logic [15:0] enable_settle_us;
        logic [15:0] command_wait_us;
        logic [15:0] data_wait_us;
        logic [15:0] clear_extra_us;
        logic [15:0] power_up_us;
    } t_cfg;

    // power-up nibbles 0x3, 0x3, 0x3, 0x2
    function automatic logic [3:0] init_nibble(input logic [1:0] idx);
        init_nibble = (idx == 2'd3) ? 4'h2 : 4'h3;
    endfunction

    // init command bytes: function set, display on, entry mode, clear
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        case (idx)
            2'd0:    init_cmd = 8'h28;
            2'd1:    init_cmd = 8'h0C;
            2'd2:    init_cmd = 8'h06;
            default: init_cmd = CMD_CLEAR;
        endcase
    endfunction

endpackage

// ----- hw/rtl/lcd4_front.sv -----
// front end: takes host requests and turns them into queue entries
// depends on lcd4_pkg
module lcd4_front (
    input  logic            start,
    input  logic            i_full,
    input  logic [2:0]      i_op,
    input  logic [7:0]      i_byte_value,
    input  logic            i_row,
    input  logic [5:0]      i_column,
    output logic            busy,
    output logic            o_push,
    output lcd4_pkg::t_req  o_req
);
    import lcd4_pkg::*;

    logic c_legal;

    assign busy = i_full;

    always_comb begin
        c_legal        = 1'b1;
        o_req.kind     = KIND_BYTE;
        o_req.rs       = 1'b0;
        o_req.byte_val = i_byte_value;
        case (i_op)
            OP_INIT: begin
                o_req.kind = KIND_INIT;
            end
            OP_CMD: begin
                o_req.rs = 1'b0;
            end
            OP_DATA: begin
                o_req.rs = 1'b1;
            end
            OP_CLEAR: begin
                o_req.kind     = KIND_CLEAR;
                o_req.byte_val = CMD_CLEAR;
            end
            OP_CURSOR: begin
                // row base 0x40 plus a 6-bit column never carries past bit 6
                o_req.byte_val = {1'b1, i_row, i_column};
            end
            default: begin
                c_legal = 1'b0;
            end
        endcase
    end

    // unused op codes are taken and dropped
    assign o_push = start && !i_full && c_legal;

endmodule

// ----- hw/rtl/lcd4_fifo.sv -----
// short request queue between front and back end
// depends on lcd4_pkg
module lcd4_fifo #(
    parameter int DEPTH = lcd4_pkg::LCD4_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcd4_pkg::t_req  i_req,
    input  logic            i_pop,
    output lcd4_pkg::t_req  o_head,
    output logic            o_empty,
    output logic            o_full
);
    import lcd4_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_req             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr, n_rd;
    logic             c_push, c_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd];
    assign c_push  = i_push && !o_full;
    assign c_pop   = i_pop && !o_empty;

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (c_push) begin
                r_wr <= n_wr;
            end
            if (c_pop) begin
                r_rd <= n_rd;
            end
            case ({c_push, c_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/lcd4_back.sv -----
// back end: walks each queued request and emits one pin state per clock while one runs
// depends on lcd4_pkg
module lcd4_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lcd4_pkg::t_cfg  i_cfg,
    input  lcd4_pkg::t_req  i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_strobe,
    output logic            o_reg_select,
    output logic            o_enable,
    output logic [3:0]      o_nibble,
    output logic [15:0]     o_wait_us,
    output logic            o_last
);
    import lcd4_pkg::*;

    typedef enum logic [1:0] {
        PH_PWR,
        PH_NIB,
        PH_BYTE,
        PH_CLRHOLD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_active, n_active;
    logic [1:0]  r_idx, n_idx;
    logic [2:0]  r_sub, n_sub;
    t_kind       r_kind;
    logic        r_rs;
    logic [7:0]  r_byte;

    logic        r_strobe, r_rs_out, r_en_out, r_last;
    logic [3:0]  r_nib_out;
    logic [15:0] r_wait_out;

    logic        c_rs, c_en, c_last;
    logic [3:0]  c_nib;
    logic [15:0] c_wait;
    logic [7:0]  c_byte;

    assign c_byte = (r_kind == KIND_INIT) ? init_cmd(r_idx) : r_byte;

    // pin state of the current step
    always_comb begin
        c_rs   = 1'b0;
        c_en   = 1'b0;
        c_nib  = 4'h0;
        c_wait = SETUP_US;
        case (r_phase)
            PH_PWR: begin
                c_wait = i_cfg.power_up_us;
            end
            PH_NIB: begin
                c_nib = init_nibble(r_idx);
                case (r_sub)
                    3'd0: begin
                        c_en   = 1'b1;
                        c_wait = i_cfg.enable_high_us;
                    end
                    3'd1: begin
                        c_wait = i_cfg.enable_settle_us;
                    end
                    default: begin
                        c_wait = (r_idx == 2'd0) ? FIRST_NIBBLE_HOLD_US : NIBBLE_HOLD_US;
                    end
                endcase
            end
            PH_BYTE: begin
                c_rs = r_rs;
                case (r_sub)
                    3'd0: begin
                        c_nib  = c_byte[7:4];
                        c_wait = SETUP_US;
                    end
                    3'd1: begin
                        c_en   = 1'b1;
                        c_nib  = c_byte[7:4];
                        c_wait = i_cfg.enable_high_us;
                    end
                    3'd2: begin
                        c_nib  = c_byte[7:4];
                        c_wait = i_cfg.enable_settle_us;
                    end
                    3'd3: begin
                        c_en   = 1'b1;
                        c_nib  = c_byte[3:0];
                        c_wait = i_cfg.enable_high_us;
                    end
                    3'd4: begin
                        c_nib  = c_byte[3:0];
                        c_wait = i_cfg.enable_settle_us;
                    end
                    default: begin
                        c_nib  = c_byte[3:0];
                        c_wait = r_rs ? i_cfg.data_wait_us : i_cfg.command_wait_us;
                    end
                endcase
            end
            PH_CLRHOLD: begin
                c_nib  = CLEAR_NIBBLE;
                c_wait = i_cfg.clear_extra_us;
            end
            default: begin
                c_nib = 4'h0;
            end
        endcase
    end

    assign c_last = (r_phase == PH_CLRHOLD)
                 || (r_phase == PH_BYTE && r_sub == 3'd5 && r_kind == KIND_BYTE);

    assign o_pop = (!r_active || c_last) && !i_empty;

    // step sequencing
    always_comb begin
        n_active = r_active;
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_sub    = r_sub;
        if (o_pop) begin
            n_active = 1'b1;
            n_phase  = (i_head.kind == KIND_INIT) ? PH_PWR : PH_BYTE;
            n_idx    = 2'd0;
            n_sub    = 3'd0;
        end else if (r_active) begin
            case (r_phase)
                PH_PWR: begin
                    n_phase = PH_NIB;
                    n_idx   = 2'd0;
                    n_sub   = 3'd0;
                end
                PH_NIB: begin
                    if (r_sub != 3'd2) begin
                        n_sub = r_sub + 3'd1;
                    end else begin
                        n_sub = 3'd0;
                        n_idx = r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            n_phase = PH_BYTE;
                        end
                    end
                end
                PH_BYTE: begin
                    if (r_sub != 3'd5) begin
                        n_sub = r_sub + 3'd1;
                    end else if (r_kind == KIND_BYTE) begin
                        n_active = 1'b0;
                    end else if (r_kind == KIND_CLEAR || r_idx == 2'd3) begin
                        n_phase = PH_CLRHOLD;
                    end else begin
                        n_sub = 3'd0;
                        n_idx = r_idx + 2'd1;
                    end
                end
                default: begin
                    n_active = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= PH_PWR;
            r_idx    <= 2'd0;
            r_sub    <= 3'd0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_sub    <= n_sub;
            r_strobe <= r_active;
            r_last   <= r_active && c_last;
        end
        if (o_pop) begin
            r_kind <= i_head.kind;
            r_rs   <= i_head.rs;
            r_byte <= i_head.byte_val;
        end
        r_rs_out   <= c_rs;
        r_en_out   <= c_en;
        r_nib_out  <= c_nib;
        r_wait_out <= c_wait;
    end

    assign o_strobe     = r_strobe;
    assign o_reg_select = r_rs_out;
    assign o_enable     = r_en_out;
    assign o_nibble     = r_nib_out;
    assign o_wait_us    = r_wait_out;
    assign o_last       = r_last;

    // every enable pulse is followed at once by its falling state
    a_pulse_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_enable) |=> (o_strobe && !o_enable))
        else $error("enable pulse not followed by enable low");

    // a request never ends with enable high
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_strobe && !o_enable))
        else $error("last pin state with enable high or no strobe");

    // a new request is only taken at the end of the previous one
    a_pop_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_active) |-> c_last)
        else $error("request taken while one is still running");

endmodule

// ----- hw/rtl/char_lcd_4bit_sequencer_top.sv -----
// top level of the character lcd 4-bit sequencer: config registers and wiring
// depends on lcd4_pkg, lcd4_front, lcd4_fifo, lcd4_back
//
// Turns host requests (init, command byte, data byte, clear, set cursor) into
// a stream of lcd pin states, one per clock while a request runs, each marked
// by o_strobe for exactly one cycle. The receiver cannot hold results off: it
// must take every strobed state (RS, EN, D4..D7 and the hold time in
// microseconds) as it comes, and o_last flags the final state of a request.
// A request is taken when start is high and busy is low. Requests wait in a
// small queue (QUEUE_DEPTH entries, four by default), so busy only rises when
// that queue is full. The back-end sequencer sets the rate: one pin state per
// clock while a request runs. The first state of a request taken by an idle
// block comes out after the queue, the step registers and the output
// registers. Unused op codes are taken and give no output. Configuration
// registers may only be written while no request is queued or running.
module char_lcd_4bit_sequencer_top #(
    parameter int QUEUE_DEPTH = lcd4_pkg::LCD4_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_byte_value,
    input  logic        i_row,
    input  logic [5:0]  i_column,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    // pin state results
    output logic        o_strobe,
    output logic        o_reg_select,
    output logic        o_enable,
    output logic [3:0]  o_nibble,
    output logic [15:0] o_wait_us,
    output logic        o_last
);
    import lcd4_pkg::*;

    t_cfg r_cfg;
    t_req w_push_req, w_head;
    logic w_push, w_pop, w_empty, w_full;

    // configuration registers, indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_high_us   <= RST_ENABLE_HIGH;
            r_cfg.enable_settle_us <= RST_ENABLE_SETTLE;
            r_cfg.command_wait_us  <= RST_COMMAND_WAIT;
            r_cfg.data_wait_us     <= RST_DATA_WAIT;
            r_cfg.clear_extra_us   <= RST_CLEAR_EXTRA;
            r_cfg.power_up_us      <= RST_POWER_UP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE_HIGH:   r_cfg.enable_high_us   <= i_cfg_wdata;
                CFG_ENABLE_SETTLE: r_cfg.enable_settle_us <= i_cfg_wdata;
                CFG_COMMAND_WAIT:  r_cfg.command_wait_us  <= i_cfg_wdata;
                CFG_DATA_WAIT:     r_cfg.data_wait_us     <= i_cfg_wdata;
                CFG_CLEAR_EXTRA:   r_cfg.clear_extra_us   <= i_cfg_wdata;
                CFG_POWER_UP:      r_cfg.power_up_us      <= i_cfg_wdata;
                default:           r_cfg                  <= r_cfg;
            endcase
        end
    end

    // front end: accept and classify each transaction
    lcd4_front u_front (
        .start        (start),
        .i_full       (w_full),
        .i_op         (i_op),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_column     (i_column),
        .busy         (busy),
        .o_push       (w_push),
        .o_req        (w_push_req)
    );

    // queue lets the host run ahead of the pin sequencer
    lcd4_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // back end: one pin state per clock while a request runs
    lcd4_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_reg_select (o_reg_select),
        .o_enable     (o_enable),
        .o_nibble     (o_nibble),
        .o_wait_us    (o_wait_us),
        .o_last       (o_last)
    );

endmodule

// ----- dv/tb_char_lcd_4bit_sequencer_top.sv -----
`timescale 1ns / 1ps
// testbench of char_lcd_4bit_sequencer_top: directed and random lcd requests,
// each checked pin state by pin state against a predictor of the sequence
// depends on lcd4_pkg and the rtl of the sequencer top level
module tb_char_lcd_4bit_sequencer_top;
    import lcd4_pkg::*;

    // generous ceiling: 432 requests plus long gaps and drains
    localparam int CYCLE_LIMIT = 400000;
    // idle cycles let pass before touching the registers, covers ignored ops
    localparam int DRAIN_PAD   = 200;

    // hd44780 init bytes and addressing, written out here on purpose
    localparam logic [7:0] FUNCTION_SET    = 8'h28;
    localparam logic [7:0] DISPLAY_ON      = 8'h0C;
    localparam logic [7:0] ENTRY_MODE      = 8'h06;
    localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
    localparam logic [6:0] ROW1_BASE       = 7'h40;
    localparam logic [7:0] SET_DDRAM       = 8'h80;

    typedef struct packed {
        logic        rs;
        logic        en;
        logic [3:0]  nib;
        logic [15:0] hold_us;
        logic        last;
    } t_pin_state;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_op;
    logic [7:0]  i_byte_value;
    logic        i_row;
    logic [5:0]  i_column;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        o_strobe;
    logic        o_reg_select;
    logic        o_enable;
    logic [3:0]  o_nibble;
    logic [15:0] o_wait_us;
    logic        o_last;

    // pin states still owed by the block, oldest first
    t_pin_state  pin_states_due[$];
    // our own copy of the timing registers, indexed by register code
    logic [15:0] timing_regs [6];
    int          mismatches;
    int          states_seen;
    int          cycle_count;

    char_lcd_4bit_sequencer_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_strobe     (o_strobe),
        .o_reg_select (o_reg_select),
        .o_enable     (o_enable),
        .o_nibble     (o_nibble),
        .o_wait_us    (o_wait_us),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake or a lost pin state ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_char_lcd_4bit_sequencer_top: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // ---------------------------------------------------------------------
    // sequence predictor: appends the pin states a request should produce
    // ---------------------------------------------------------------------
    function automatic void predict_state(input logic rs, input logic en,
                                          input logic [3:0] nib, input logic [15:0] hold);
        t_pin_state s;
        s.rs      = rs;
        s.en      = en;
        s.nib     = nib;
        s.hold_us = hold;
        s.last    = 1'b0;
        pin_states_due.push_back(s);
    endfunction

    // one enable pulse: en high for the high time, then low for the settle time
    function automatic void predict_pulse(input logic rs, input logic [3:0] nib);
        predict_state(rs, 1'b1, nib, timing_regs[CFG_ENABLE_HIGH]);
        predict_state(rs, 1'b0, nib, timing_regs[CFG_ENABLE_SETTLE]);
    endfunction

    // a byte: rs setup with the high nibble already shown, two pulses, settle
    function automatic void predict_byte(input logic rs, input logic [7:0] b);
        predict_state(rs, 1'b0, b[7:4], SETUP_US);
        predict_pulse(rs, b[7:4]);
        predict_pulse(rs, b[3:0]);
        predict_state(rs, 1'b0, b[3:0],
                      rs ? timing_regs[CFG_DATA_WAIT] : timing_regs[CFG_COMMAND_WAIT]);
    endfunction

    function automatic void predict_request(input logic [2:0] op, input logic [7:0] b,
                                            input logic row, input logic [5:0] col);
        int         prior_count;
        logic [6:0] addr;
        prior_count = pin_states_due.size();
        case (op)
            OP_INIT: begin
                // power-up wait with all lines low, then the wake-up nibbles
                predict_state(1'b0, 1'b0, 4'h0, timing_regs[CFG_POWER_UP]);
                for (int i = 0; i < 4; i++) begin
                    predict_pulse(1'b0, (i == 3) ? FOUR_BIT_NIBBLE : WAKE_NIBBLE);
                    predict_state(1'b0, 1'b0, (i == 3) ? FOUR_BIT_NIBBLE : WAKE_NIBBLE,
                                  (i == 0) ? FIRST_NIBBLE_HOLD_US : NIBBLE_HOLD_US);
                end
                predict_byte(1'b0, FUNCTION_SET);
                predict_byte(1'b0, DISPLAY_ON);
                predict_byte(1'b0, ENTRY_MODE);
                predict_byte(1'b0, CMD_CLEAR);
                predict_state(1'b0, 1'b0, CLEAR_NIBBLE, timing_regs[CFG_CLEAR_EXTRA]);
            end
            OP_CMD:  predict_byte(1'b0, b);
            OP_DATA: predict_byte(1'b1, b);
            OP_CLEAR: begin
                predict_byte(1'b0, CMD_CLEAR);
                predict_state(1'b0, 1'b0, CLEAR_NIBBLE, timing_regs[CFG_CLEAR_EXTRA]);
            end
            OP_CURSOR: begin
                // column is added unchecked; a six-bit column never carries past bit 6
                addr = (row ? ROW1_BASE : 7'h00) + 7'(col);
                predict_byte(1'b0, SET_DDRAM | {1'b0, addr});
            end
            default: ;  // unused op codes are swallowed silently
        endcase
        if (pin_states_due.size() > prior_count)
            pin_states_due[pin_states_due.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // checker: every strobed pin state against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pin_state want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pin_states_due.size() == 0) begin
                report_mismatch($sformatf("pin state %0d arrived with nothing pending",
                                          states_seen));
            end else begin
                want = pin_states_due.pop_front();
                if (o_reg_select !== want.rs)
                    report_mismatch($sformatf("state %0d rs got %b want %b",
                                              states_seen, o_reg_select, want.rs));
                if (o_enable !== want.en)
                    report_mismatch($sformatf("state %0d en got %b want %b",
                                              states_seen, o_enable, want.en));
                if (o_nibble !== want.nib)
                    report_mismatch($sformatf("state %0d nibble got %h want %h",
                                              states_seen, o_nibble, want.nib));
                if (o_wait_us !== want.hold_us)
                    report_mismatch($sformatf("state %0d wait got %0d want %0d",
                                              states_seen, o_wait_us, want.hold_us));
                if (o_last !== want.last)
                    report_mismatch($sformatf("state %0d last got %b want %b",
                                              states_seen, o_last, want.last));
            end
            states_seen++;
        end
    end

    // ---------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------

    // one request transaction; start stays high into the next call if no gap
    task automatic send_request(input logic [2:0] op, input logic [7:0] b,
                                input logic row, input logic [5:0] col);
        start        <= 1'b1;
        i_op         <= op;
        i_byte_value <= b;
        i_row        <= row;
        i_column     <= col;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_request(op, b, row, col);
    endtask

    // mostly back to back or short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 0;
        else if (r < 88) return $urandom_range(1, 3);
        else             return $urandom_range(10, 60);
    endfunction

    // idle the request side, with junk on the payload while start is low
    task automatic pause_sender(input int n);
        if (n > 0) begin
            start        <= 1'b0;
            i_op         <= 3'($urandom);
            i_byte_value <= 8'($urandom);
            i_row        <= 1'($urandom);
            i_column     <= 6'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every owed pin state has come, then idle for pad cycles
    task automatic drain(input int pad);
        start <= 1'b0;
        while (pin_states_due.size() != 0) @(posedge i_clk);
        repeat (pad) @(posedge i_clk);
    endtask

    // writes all six timing registers, then a stray index that must be ignored
    task automatic apply_settings(input logic [15:0] vals [6]);
        for (int i = CFG_ENABLE_HIGH; i <= CFG_POWER_UP; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= 3'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            timing_regs[i] = vals[i];
        end
        i_cfg_idx   <= 3'(int'(CFG_POWER_UP) + $urandom_range(1, 2));
        i_cfg_wdata <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // zero, all ones and a few tiny values appear often
    function automatic logic [15:0] random_setting();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)       return 16'h0000;
        else if (r < 4)  return 16'hFFFF;
        else if (r == 4) return 16'($urandom_range(1, 10));
        else             return 16'($urandom);
    endfunction

    task automatic apply_random_settings();
        logic [15:0] vals [6];
        foreach (vals[i]) vals[i] = random_setting();
        apply_settings(vals);
    endtask

    // weighted towards byte traffic, a few inits, out-of-range columns and junk ops
    task automatic random_request(input bit with_gaps);
        int         pick;
        logic [2:0] op;
        logic [5:0] col;
        pick = $urandom_range(0, 99);
        if (pick < 5)       op = OP_INIT;
        else if (pick < 30) op = OP_CMD;
        else if (pick < 65) op = OP_DATA;
        else if (pick < 75) op = OP_CLEAR;
        else if (pick < 95) op = OP_CURSOR;
        else                op = 3'(int'(OP_CURSOR) + $urandom_range(1, 3));
        col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                          : 6'($urandom_range(0, 39));
        send_request(op, 8'($urandom), 1'($urandom), col);
        if (with_gaps) pause_sender(gap_len());
    endtask

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // every request kind against the timing registers as they come out of reset
    task automatic test_reset_timing();
        send_request(OP_INIT, 8'($urandom), 1'($urandom), 6'($urandom));
        pause_sender(gap_len());
        send_request(OP_CMD, 8'($urandom), 1'($urandom), 6'($urandom));
        pause_sender(gap_len());
        send_request(OP_DATA, 8'($urandom), 1'($urandom), 6'($urandom));
        send_request(OP_CLEAR, 8'($urandom), 1'($urandom), 6'($urandom));
        pause_sender(gap_len());
        send_request(OP_CURSOR, 8'($urandom), 1'b1, 6'd5);
        drain(DRAIN_PAD);
    endtask

    // byte and column extremes and unused ops under all-zero timings, then all-ones timings
    task automatic test_edge_cases();
        logic [15:0] vals [6];
        foreach (vals[i]) vals[i] = 16'h0000;
        apply_settings(vals);
        send_request(OP_CMD,    8'h00, 1'b0, 6'd0);
        send_request(OP_CMD,    8'hFF, 1'b1, 6'd63);
        send_request(OP_DATA,   8'h00, 1'b0, 6'd0);
        send_request(OP_DATA,   8'hFF, 1'b1, 6'd63);
        send_request(OP_CURSOR, 8'($urandom), 1'b0, 6'd0);
        send_request(OP_CURSOR, 8'($urandom), 1'b1, 6'd39);
        // past the last column: the address still stays inside seven bits
        send_request(OP_CURSOR, 8'($urandom), 1'b1, 6'd63);
        send_request(OP_CURSOR, 8'($urandom), 1'b0, 6'd63);
        // op codes beyond set cursor are taken but produce nothing
        for (int u = int'(OP_CURSOR) + 1; u < (1 << $bits(i_op)); u++)
            send_request(3'(u), 8'($urandom), 1'($urandom), 6'($urandom));
        send_request(OP_CLEAR, 8'($urandom), 1'($urandom), 6'($urandom));
        send_request(OP_INIT,  8'($urandom), 1'($urandom), 6'($urandom));
        drain(DRAIN_PAD);

        foreach (vals[i]) vals[i] = 16'hFFFF;
        apply_settings(vals);
        send_request(OP_INIT,   8'($urandom), 1'($urandom), 6'($urandom));
        pause_sender(gap_len());
        send_request(OP_DATA,   8'hA5, 1'b0, 6'd0);
        send_request(OP_CURSOR, 8'($urandom), 1'b1, 6'd0);
        send_request(OP_CLEAR,  8'($urandom), 1'($urandom), 6'($urandom));
        drain(DRAIN_PAD);
    endtask

    // several register settings, random traffic and gaps in each phase
    task automatic test_random_phases();
        for (int phase = 0; phase < 5; phase++) begin
            apply_random_settings();
            for (int n = 0; n < 70; n++) begin
                // one hold-off mid-phase until the block has emptied out
                if (phase == 1 && n == 35) drain(0);
                random_request(1'b1);
            end
            drain(DRAIN_PAD);
        end
    endtask

    // start held high throughout so the request queue fills and busy pushes back
    task automatic test_back_to_back();
        apply_random_settings();
        repeat (60) random_request(1'b0);
        drain(DRAIN_PAD);
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_op         <= OP_INIT;
        i_byte_value <= 8'h00;
        i_row        <= 1'b0;
        i_column     <= 6'd0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_ENABLE_HIGH;
        i_cfg_wdata  <= 16'h0000;
        mismatches   = 0;
        states_seen  = 0;
        cycle_count  = 0;
        timing_regs[CFG_ENABLE_HIGH]   = RST_ENABLE_HIGH;
        timing_regs[CFG_ENABLE_SETTLE] = RST_ENABLE_SETTLE;
        timing_regs[CFG_COMMAND_WAIT]  = RST_COMMAND_WAIT;
        timing_regs[CFG_DATA_WAIT]     = RST_DATA_WAIT;
        timing_regs[CFG_CLEAR_EXTRA]   = RST_CLEAR_EXTRA;
        timing_regs[CFG_POWER_UP]      = RST_POWER_UP;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_timing();
        test_edge_cases();
        test_random_phases();
        test_back_to_back();

        if (pin_states_due.size() != 0)
            report_mismatch($sformatf("%0d pin states never arrived",
                                      pin_states_due.size()));
        if (mismatches == 0)
            $display("tb_char_lcd_4bit_sequencer_top: clean");
        else
            $display("tb_char_lcd_4bit_sequencer_top: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lcd4_pkg.sv
hw/rtl/lcd4_front.sv
hw/rtl/lcd4_fifo.sv
hw/rtl/lcd4_back.sv
hw/rtl/char_lcd_4bit_sequencer_top.sv
dv/tb_char_lcd_4bit_sequencer_top.sv
